/* design/zip_central_dir_parser_top_defines.svh */
// Assertion macros shared by the zip central directory parser modules.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ZIP_CENTRAL_DIR_PARSER_TOP_DEFINES_SVH
`define ZIP_CENTRAL_DIR_PARSER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Clocked check that is switched off while reset is asserted.
`define ZCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ZCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ZCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define ZCD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* design/zcd_pkg.sv */
// Shared types and constants of the zip central directory parser.
// Used by zcd_parser, zcd_out_fifo and zip_central_dir_parser_top.
package zcd_pkg;

  // Fixed central directory header layout.
  localparam int unsigned HeaderBytes = 46;
  localparam int unsigned PosW        = $clog2(HeaderBytes);
  localparam logic [31:0] CdSignature = 32'h0201_4b50;
  localparam logic [15:0] FlagEncrypt = 16'h0001;
  localparam logic [15:0] MethodStore = 16'h0000;

  // Default depth of the result queue.
  localparam int unsigned OutDepth = 4;

  // Register index of entries_expected.
  localparam logic [0:0] RegEntriesExp = 1'b0;

  typedef enum logic [1:0] {
    KindSummary = 2'd0,
    KindName    = 2'd1,
    KindError   = 2'd2,
    KindDone    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ErrSignature  = 2'd0,
    ErrEncrypted  = 2'd1,
    ErrCompressed = 2'd2
  } err_e;

  typedef enum logic [5:0] {
    PhIdle   = 6'b000001,
    PhHeader = 6'b000010,
    PhName   = 6'b000100,
    PhSkip   = 6'b001000,
    PhDone   = 6'b010000,
    PhError  = 6'b100000
  } phase_e;

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] crc;
    logic [31:0] size;
    logic [15:0] dos_time;
    logic [15:0] dos_date;
    logic [15:0] name_length;
    logic [31:0] local_offset;
    logic [7:0]  name_char;
    err_e        error_code;
    logic        entry_last;
  } res_t;

  // Write strobes from the parser into the result queue.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

/* design/zcd_parser.sv */
// Per-byte parse logic: header shift register, phase machine and counters.
// Depends on zcd_pkg and the assertion macros in the defines header.
`include "zip_central_dir_parser_top_defines.svh"

module zcd_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  input  logic           start_i,
  input  logic [15:0]    entries_expected_i,
  output zcd_pkg::push_t push_o,
  output zcd_pkg::res_t  res0_o,
  output zcd_pkg::res_t  res1_o
);

  localparam int unsigned HdrN = zcd_pkg::HeaderBytes;
  localparam int unsigned PosW = zcd_pkg::PosW;
  localparam logic [PosW-1:0] PosLast = PosW'(HdrN - 1);

  zcd_pkg::phase_e phase_q, phase_d, phase_eff;
  logic [PosW-1:0] pos_q, pos_d, pos_base;
  logic [15:0]     name_q, name_d, name_dec, name_len;
  logic [16:0]     skip_q, skip_d, skip_dec, skip_sum;
  logic [15:0]     done_q, done_d, done_base, done_inc;
  logic            fin_done;
  logic            hdr_step;
  logic [7:0]      hdr_q [HdrN];
  logic [7:0]      hdr_d [HdrN];
  logic [31:0]     sig;
  logic [15:0]     flags, method;
  zcd_pkg::res_t   res_done;

  // The header enters at the top and moves down, so after a full header
  // byte k sits at index k.
  assign hdr_step = step_i &&
                    (start_i ? (entries_expected_i != 16'd0) : (phase_q == zcd_pkg::PhHeader));

  always_comb begin
    for (int i = 0; i < HdrN - 1; i++) begin
      hdr_d[i] = hdr_q[i+1];
    end
    hdr_d[HdrN-1] = byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (hdr_step) begin
      hdr_q <= hdr_d;
    end
  end

  // Header fields, read from the completed header on its last byte.
  assign sig      = {hdr_d[3], hdr_d[2], hdr_d[1], hdr_d[0]};
  assign flags    = {hdr_d[9], hdr_d[8]};
  assign method   = {hdr_d[11], hdr_d[10]};
  assign name_len = {hdr_d[29], hdr_d[28]};
  assign skip_sum = {1'b0, hdr_d[31], hdr_d[30]} + {1'b0, hdr_d[33], hdr_d[32]};

  // A start byte clears the parse state before the byte itself is parsed.
  assign phase_eff = start_i ? zcd_pkg::PhHeader : phase_q;
  assign pos_base  = start_i ? '0 : pos_q;
  assign done_base = start_i ? 16'd0 : done_q;
  assign done_inc  = done_base + 16'd1;
  assign fin_done  = (done_inc >= entries_expected_i);
  assign name_dec  = name_q - 16'd1;
  assign skip_dec  = skip_q - 17'd1;

  always_comb begin
    res_done      = '0;
    res_done.kind = zcd_pkg::KindDone;
  end

  // Phase machine and result generation for one byte.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    name_d  = name_q;
    skip_d  = skip_q;
    done_d  = done_q;
    push_o  = '0;
    res0_o  = '0;
    res1_o  = '0;
    if (step_i) begin
      if (start_i) begin
        pos_d  = '0;
        name_d = 16'd0;
        skip_d = 17'd0;
        done_d = 16'd0;
      end
      if (start_i && (entries_expected_i == 16'd0)) begin
        phase_d      = zcd_pkg::PhDone;
        push_o.first = 1'b1;
        res0_o       = res_done;
      end else begin
        case (phase_eff)
          zcd_pkg::PhHeader: begin
            phase_d = zcd_pkg::PhHeader;
            if (pos_base != PosLast) begin
              pos_d = pos_base + 1'b1;
            end else begin
              pos_d        = '0;
              push_o.first = 1'b1;
              if (sig != zcd_pkg::CdSignature) begin
                res0_o.kind       = zcd_pkg::KindError;
                res0_o.error_code = zcd_pkg::ErrSignature;
                phase_d           = zcd_pkg::PhError;
              end else if ((flags & zcd_pkg::FlagEncrypt) != 16'd0) begin
                res0_o.kind       = zcd_pkg::KindError;
                res0_o.error_code = zcd_pkg::ErrEncrypted;
                phase_d           = zcd_pkg::PhError;
              end else if (method != zcd_pkg::MethodStore) begin
                res0_o.kind       = zcd_pkg::KindError;
                res0_o.error_code = zcd_pkg::ErrCompressed;
                phase_d           = zcd_pkg::PhError;
              end else begin
                res0_o.kind         = zcd_pkg::KindSummary;
                res0_o.crc          = {hdr_d[19], hdr_d[18], hdr_d[17], hdr_d[16]};
                res0_o.size         = {hdr_d[27], hdr_d[26], hdr_d[25], hdr_d[24]};
                res0_o.dos_time     = {hdr_d[13], hdr_d[12]};
                res0_o.dos_date     = {hdr_d[15], hdr_d[14]};
                res0_o.name_length  = name_len;
                res0_o.local_offset = {hdr_d[45], hdr_d[44], hdr_d[43], hdr_d[42]};
                res0_o.entry_last   = (name_len == 16'd0);
                name_d              = name_len;
                skip_d              = skip_sum;
                if (name_len != 16'd0) begin
                  phase_d = zcd_pkg::PhName;
                end else if (skip_sum != 17'd0) begin
                  phase_d = zcd_pkg::PhSkip;
                end else begin
                  // Entry ends on its header.
                  done_d = done_inc;
                  if (fin_done) begin
                    phase_d       = zcd_pkg::PhDone;
                    push_o.second = 1'b1;
                    res1_o        = res_done;
                  end else begin
                    phase_d = zcd_pkg::PhHeader;
                  end
                end
              end
            end
          end
          zcd_pkg::PhName: begin
            push_o.first     = 1'b1;
            res0_o.kind      = zcd_pkg::KindName;
            res0_o.name_char = byte_i;
            name_d           = name_dec;
            if (name_dec == 16'd0) begin
              res0_o.entry_last = 1'b1;
              if (skip_q != 17'd0) begin
                phase_d = zcd_pkg::PhSkip;
              end else begin
                done_d = done_inc;
                if (fin_done) begin
                  phase_d       = zcd_pkg::PhDone;
                  push_o.second = 1'b1;
                  res1_o        = res_done;
                end else begin
                  phase_d = zcd_pkg::PhHeader;
                  pos_d   = '0;
                end
              end
            end
          end
          zcd_pkg::PhSkip: begin
            skip_d = skip_dec;
            if (skip_dec == 17'd0) begin
              done_d = done_inc;
              if (fin_done) begin
                phase_d      = zcd_pkg::PhDone;
                push_o.first = 1'b1;
                res0_o       = res_done;
              end else begin
                phase_d = zcd_pkg::PhHeader;
                pos_d   = '0;
              end
            end
          end
          default: begin
            // Idle, done or halted on an error: the byte is dropped.
          end
        endcase
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= zcd_pkg::PhIdle;
      pos_q   <= '0;
      name_q  <= 16'd0;
      skip_q  <= 17'd0;
      done_q  <= 16'd0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      name_q  <= name_d;
      skip_q  <= skip_d;
      done_q  <= done_d;
    end
  end

  `ZCD_ASSERT(a_second_needs_first, clk_i, rst_ni, push_o.second |-> push_o.first, "second result without first")
  `ZCD_ASSERT(a_second_is_done, clk_i, rst_ni, push_o.second |-> (res1_o.kind == zcd_pkg::KindDone), "second result is not done")
  `ZCD_ASSERT(a_no_push_idle, clk_i, rst_ni, !step_i |-> !push_o.first, "result without a byte")
  `ZCD_ASSERT(a_done_phase, clk_i, rst_ni, ((push_o.first && (res0_o.kind == zcd_pkg::KindDone)) || push_o.second) |=> (phase_q == zcd_pkg::PhDone), "done result without done phase")

endmodule

/* design/zcd_out_fifo.sv */
// Result queue: takes up to two results a cycle, gives one a cycle while
// m_ready_i is high. Depends on zcd_pkg and the defines header's macros.
`include "zip_central_dir_parser_top_defines.svh"

module zcd_out_fifo #(
  parameter int unsigned Depth = zcd_pkg::OutDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  zcd_pkg::push_t push_i,
  input  zcd_pkg::res_t  res0_i,
  input  zcd_pkg::res_t  res1_i,
  output logic           room_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output zcd_pkg::res_t  m_res_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  zcd_pkg::res_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, wp_d, wp_next, wp_next2, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  // Room for two results, the most one byte can cause.
  assign room_o    = (cnt_q <= CntW'(Depth - 2));
  assign m_valid_o = (cnt_q != '0);
  assign m_res_o   = mem_q[rp_q];
  assign pop       = m_valid_o && m_ready_i;

  // Pointer arithmetic with wrap at the depth.
  assign wp_next  = (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
  assign wp_next2 = (wp_next == PtrLast) ? '0 : wp_next + 1'b1;

  always_comb begin
    wp_d = wp_q;
    if (push_i.first && push_i.second) begin
      wp_d = wp_next2;
    end else if (push_i.first) begin
      wp_d = wp_next;
    end
    rp_d = rp_q;
    if (pop) begin
      rp_d = (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push_i.first) + CntW'(push_i.second) - CntW'(pop);
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wp_q] <= res0_i;
    end
    if (push_i.second) begin
      mem_q[wp_next] <= res1_i;
    end
  end

  // Queue control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  `ZCD_ASSERT_ALWAYS(a_cnt_bound, clk_i, !rst_ni || (cnt_q <= CntW'(Depth)), "queue count beyond depth")
  `ZCD_ASSERT(a_push_not_full, clk_i, rst_ni, push_i.first |-> (cnt_q <= CntW'(Depth - 1)), "push into a full queue")
  `ZCD_ASSERT(a_pop_count, clk_i, rst_ni, (pop && !push_i.first) |=> (CntW'(cnt_q + 1'b1) == $past(cnt_q)), "pop did not lower the count")

endmodule

/* design/zip_central_dir_parser_top.sv */
// Zip central directory parser: one byte request per cycle in; entry summaries, name
// bytes, error and done results out. A result is valid once its byte has passed the
// input register and been written into the result queue. Throughput is one byte per
// cycle; a byte that ends a directory can cause two results, which leave one at a time.
// The input stalls only while the queue holds more than OutDepth - 2 results.
// rst_ni is asynchronous, active low: parser idle, queue empty, entries_expected zero.
module zip_central_dir_parser_top #(
  parameter int unsigned OutDepth = zcd_pkg::OutDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Byte stream in.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]   s_axis_tuser,   // [0] start_flag
  // Results out.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] entry_crc, [63:32] entry_size, [79:64] dos_time, [95:80] dos_date,
  // [111:96] name_length, [143:112] local_offset, [151:144] name_char,
  // [153:152] error_code, [159:154] zero
  output logic [159:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // [1:0] result_kind
  output logic         m_axis_tlast,   // entry_last
  // Configuration.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic           in_valid_q;
  logic [7:0]     in_byte_q;
  logic           in_start_q;
  logic           consume;
  logic           room;
  logic [15:0]    entries_exp_q;
  zcd_pkg::push_t push;
  zcd_pkg::res_t  res0, res1, out_res;

  // Register port: one register, written in the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == zcd_pkg::RegEntriesExp) ? {16'd0, entries_exp_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_exp_q <= 16'd0;
    end else if (psel && penable && pwrite && (paddr[2:2] == zcd_pkg::RegEntriesExp)) begin
      entries_exp_q <= pwdata[15:0];
    end
  end

  // Input register: drained whenever the queue can take a full step's output.
  assign consume       = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser[0];
    end
  end

  zcd_parser u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (consume),
    .byte_i             (in_byte_q),
    .start_i            (in_start_q),
    .entries_expected_i (entries_exp_q),
    .push_o             (push),
    .res0_o             (res0),
    .res1_o             (res1)
  );

  zcd_out_fifo #(
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .res0_i    (res0),
    .res1_i    (res1),
    .room_o    (room),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (out_res)
  );

  // Pack the result onto the stream.
  assign m_axis_tdata = {6'd0, out_res.error_code, out_res.name_char, out_res.local_offset,
                         out_res.name_length, out_res.dos_date, out_res.dos_time,
                         out_res.size, out_res.crc};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.entry_last;

endmodule
